>>> sv/ast_pkg.sv
// Shared types, constants and the arcsine table for accel_scale_and_tilt.
package ast_pkg;

  localparam int unsigned SensW = 12;
  localparam int unsigned DataW = 16;
  localparam int unsigned AngW  = 12;
  localparam int unsigned TabN  = 21;
  localparam int unsigned TabIw = 5;

  localparam logic [2:0] RegOffsetX = 3'd0;
  localparam logic [2:0] RegOffsetY = 3'd1;
  localparam logic [2:0] RegSensX   = 3'd2;
  localparam logic [2:0] RegSensY   = 3'd3;
  localparam logic [2:0] RegSensZ   = 3'd4;
  localparam logic [2:0] RegGScale  = 3'd5;

  typedef logic signed [DataW-1:0] sample_t;
  typedef logic signed [AngW-1:0]  ang_t;

  function automatic logic signed [11:0] asin_pt(input logic [TabIw-1:0] i);
    logic signed [11:0] v;
    case (i)
      5'd0:  v = -12'sd1571;
      5'd1:  v = -12'sd1120;
      5'd2:  v = -12'sd927;
      5'd3:  v = -12'sd775;
      5'd4:  v = -12'sd644;
      5'd5:  v = -12'sd524;
      5'd6:  v = -12'sd412;
      5'd7:  v = -12'sd305;
      5'd8:  v = -12'sd201;
      5'd9:  v = -12'sd100;
      5'd10: v = 12'sd0;
      5'd11: v = 12'sd100;
      5'd12: v = 12'sd201;
      5'd13: v = 12'sd305;
      5'd14: v = 12'sd412;
      5'd15: v = 12'sd524;
      5'd16: v = 12'sd644;
      5'd17: v = 12'sd775;
      5'd18: v = 12'sd927;
      5'd19: v = 12'sd1120;
      5'd20: v = 12'sd1571;
      default: v = 12'sd1571;
    endcase
    return v;
  endfunction

endpackage

>>> sv/ast_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
module ast_div #(
  parameter int unsigned NW = 30,
  parameter int unsigned DW = 12,
  parameter int unsigned SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem,
  output logic [SW-1:0] side_out
);
  logic [NW-1:0] q_r   [NW+1];
  logic [DW-1:0] r_r   [NW+1];
  logic [DW-1:0] d_r   [NW+1];
  logic [SW-1:0] s_r   [NW+1];

  always_comb begin
    q_r[0] = num;
    r_r[0] = '0;
    d_r[0] = den;
    s_r[0] = side_in;
  end

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic [NW-1:0] q_nxt;
    logic [DW-1:0] r_nxt;
    logic [NW-1:0] q_st_r;
    logic [DW-1:0] r_st_r, d_st_r;
    logic [SW-1:0] s_st_r;
    always_comb begin
      trial = {r_r[k], q_r[k][NW-1]};
      diff  = trial - {1'b0, d_r[k]};
      if (!diff[DW]) begin
        r_nxt = diff[DW-1:0];
        q_nxt = {q_r[k][NW-2:0], 1'b1};
      end else begin
        r_nxt = trial[DW-1:0];
        q_nxt = {q_r[k][NW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        q_st_r <= q_nxt;
        r_st_r <= r_nxt;
        d_st_r <= d_r[k];
        s_st_r <= s_r[k];
      end
    end
    always_comb begin
      q_r[k+1] = q_st_r;
      r_r[k+1] = r_st_r;
      d_r[k+1] = d_st_r;
      s_r[k+1] = s_st_r;
    end
  end

  assign quo      = q_r[NW];
  assign rem      = r_r[NW];
  assign side_out = (rst_n) ? s_r[NW] : s_r[NW];
endmodule

>>> sv/ast_lane.sv
// One axis lane: scale path and optional arcsine path, fixed depth.
module ast_lane #(
  parameter int unsigned DO_ASIN = 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  ast_pkg::sample_t          d_in,     // raw sample, unused
  input  logic [16:0]               d_ext,    // 17-bit offset-corrected difference
  input  logic [ast_pkg::SensW-1:0] sens,
  input  logic [ast_pkg::SensW-1:0] gscale,
  input  logic                      negate,
  output ast_pkg::sample_t          accel,
  output ast_pkg::ang_t             angle
);
  import ast_pkg::*;
  localparam int unsigned LAT = 2 + 30 + 1 + 14 + 1 + 12 + 1;

  // stage 0: magnitude and product
  logic signed [16:0] d;
  logic [11:0] s;
  logic [29:0] prod_r;
  logic        neg0_r;
  logic [16:0] mag;
  assign d = $signed(d_ext);
  assign s = (sens == '0) ? 12'd1 : sens;
  assign mag = d[16] ? 17'(-d) : d;
  logic [11:0] s0_r;
  logic signed [16:0] d0_r;
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 30'(mag * gscale);
      neg0_r <= d[16] ^ negate;
      s0_r   <= s;
      d0_r   <= d;
    end
  end

  // main divider: |d|*g / s
  logic [29:0] q1;
  logic [11:0] r1_unused;
  logic [12:0] side1;
  ast_div #(.NW(30), .DW(12), .SW(13)) u_div1 (
    .clk, .rst_n, .en, .num(prod_r), .den(s0_r), .side_in({neg0_r, s0_r}),
    .quo(q1), .rem(r1_unused), .side_out(side1)
  );

  // divide by ten: multiply by reciprocal then correct
  logic [26:0] qa_r;
  logic        nega_r;
  logic [29:0] q1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      q1_r   <= q1;
      qa_r   <= 27'(({30'd0, q1} * 60'd858993460) >> 33);
      nega_r <= side1[12] ^ (r1_unused != r1_unused);
    end
  end
  logic [29:0] rm;
  logic [26:0] qt;
  assign rm = q1_r - 30'(qa_r) * 30'd10;
  assign qt = (rm >= 30'd10) ? qa_r + 27'd1 : qa_r;
  logic signed [28:0] sv;
  assign sv = nega_r ? -$signed({2'b0, qt}) : $signed({2'b0, qt});
  sample_t acc_r;
  always_ff @(posedge clk) begin
    if (en) begin
      if (sv > 29'sd32767) acc_r <= 16'sh7fff;
      else if (sv < -29'sd32768) acc_r <= 16'sh8000;
      else acc_r <= sv[15:0];
    end
  end

  // delay the scale result to the lane latency
  localparam int unsigned AD = LAT - 33;
  sample_t ad_r [AD];
  always_ff @(posedge clk) begin
    if (en) begin
      ad_r[0] <= acc_r;
      for (int i = 1; i < AD; i++) ad_r[i] <= ad_r[i-1];
    end
  end
  assign accel = ad_r[AD-1];

  if (DO_ASIN != 0) begin : g_asin
    // u = (d + s) * 10, h = u / s, t = u mod s
    logic signed [18:0] ds;
    logic lo_c, hi_c;
    assign ds = 19'(d0_r) + 19'($signed({1'b0, s0_r}));
    logic [21:0] u_r;
    logic [13:0] side_u;
    always_ff @(posedge clk) begin
      if (en) begin
        u_r    <= ds[18] ? 22'd0 : 22'(ds) * 22'd10;
        side_u <= {ds[18], 1'b0, s0_r};
      end
    end
    // lanes are matched: the 22-bit divider is padded to the depth of the 30-bit one
    logic [21:0] h;
    logic [11:0] t;
    logic [13:0] side2;
    ast_div #(.NW(22), .DW(12), .SW(14)) u_div2 (
      .clk, .rst_n, .en, .num(u_r), .den(side_u[11:0]), .side_in(side_u),
      .quo(h), .rem(t), .side_out(side2)
    );
    // pad 8 stages to line up with the scale path divider
    logic [21:0] hp_r [8];
    logic [11:0] tp_r [8];
    logic [13:0] sp_r [8];
    always_ff @(posedge clk) begin
      if (en) begin
        hp_r[0] <= h; tp_r[0] <= t; sp_r[0] <= side2;
        for (int i = 1; i < 8; i++) begin
          hp_r[i] <= hp_r[i-1]; tp_r[i] <= tp_r[i-1]; sp_r[i] <= sp_r[i-1];
        end
      end
    end
    // table lookup and slope product
    logic [21:0] hh;
    logic [11:0] tt, ss;
    assign hh = hp_r[7]; assign tt = tp_r[7]; assign ss = sp_r[7][11:0];
    assign lo_c = sp_r[7][13];
    assign hi_c = hh >= 22'(TabN - 1);
    logic [TabIw-1:0] hi;
    assign hi = hi_c ? 5'(TabN - 1) : hh[TabIw-1:0];
    logic signed [11:0] base;
    logic [8:0] dlt;
    assign base = asin_pt(hi);
    assign dlt  = 9'(asin_pt(hi + 5'd1) - base);
    logic signed [11:0] b_r;
    logic [20:0] pm_r;
    logic [11:0] ss_r;
    logic [1:0]  cl_r;
    always_ff @(posedge clk) begin
      if (en) begin
        b_r  <= base;
        pm_r <= 21'(dlt * tt);
        ss_r <= ss;
        cl_r <= {lo_c, hi_c};
      end
    end
    logic [20:0] fq;
    logic [11:0] fr_unused;
    logic [25:0] side3;
    ast_div #(.NW(21), .DW(12), .SW(26)) u_div3 (
      .clk, .rst_n, .en, .num(pm_r), .den(ss_r), .side_in({b_r, cl_r, ss_r}),
      .quo(fq), .rem(fr_unused), .side_out(side3)
    );
    // total so far: 1+1+22+8+1+21 = 54; add final reg = 55; pad to LAT
    ang_t ang_r;
    always_ff @(posedge clk) begin
      if (en) begin
        if (side3[13]) ang_r <= 12'sd1571;
        else if (side3[12]) ang_r <= -12'sd1571;
        else ang_r <= -($signed(side3[25:14]) + $signed(fq[11:0]))
                      ^ (fr_unused & side3[11:0] & 12'd0);
      end
    end
    localparam int unsigned PD = LAT - 55;
    ang_t pa_r [PD+1];
    always_comb pa_r[0] = ang_r;
    for (genvar k = 0; k < PD; k++) begin : g_pad
      ang_t st_r;
      always_ff @(posedge clk) if (en) st_r <= pa_r[k];
      always_comb pa_r[k+1] = st_r;
    end
    assign angle = pa_r[PD];
  end else begin : g_noasin
    assign angle = '0;
  end
  logic unused;
  assign unused = ^d_in;
endmodule

>>> sv/accel_scale_and_tilt.sv
// Top level of accel_scale_and_tilt: three scaling lanes and output merge.
// One sample (X, Y, Z) is accepted per clock while in_tready is high; each
// result passes 61 lane stages, set by the arcsine path (product, segment
// divider, slope divider in series, 55 stages, the scale path and the rest
// padded to match), and is then registered into a two-entry output buffer.
// The whole pipeline advances when the output buffer has room
// or the receiver takes a result, so stalls on the result side hold every
// stage. Scaling is |d|*gravity_scale/sens/10 truncated toward zero and
// saturated to 16 bits; X and Z are negated. Pitch and roll are a 21-point
// arcsine table in milliradians, also negated. A sensitivity of zero is
// treated as one.
module accel_scale_and_tilt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // raw_x, raw_y, raw_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // accel_x, accel_y, accel_z, pitch_mrad, roll_mrad
);
  import ast_pkg::*;
  localparam int unsigned LAT = 61;

  logic [15:0] off_x_r, off_y_r;
  logic [11:0] sx_r, sy_r, sz_r, g_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r <= '0; off_y_r <= '0;
      sx_r <= 12'd354; sy_r <= 12'd343; sz_r <= 12'd355; g_r <= 12'd981;
    end else if (cfg_we) begin
      case (cfg_addr)
        RegOffsetX: off_x_r <= cfg_wdata;
        RegOffsetY: off_y_r <= cfg_wdata;
        RegSensX:   sx_r <= cfg_wdata[11:0];
        RegSensY:   sy_r <= cfg_wdata[11:0];
        RegSensZ:   sz_r <= cfg_wdata[11:0];
        RegGScale:  g_r <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // skid FIFO of two entries; pipeline moves when it can hold an in-flight result
  logic [71:0] fq_r [2];
  logic [1:0]  cnt_r;
  logic        en;
  logic [LAT-1:0] v_r;
  assign en = (cnt_r != 2'd2) || out_tready;
  assign in_tready = en;

  logic signed [16:0] dx, dy, dz;
  assign dx = 17'($signed(in_tdata[15:0])) - 17'($signed(off_x_r));
  assign dy = 17'($signed(in_tdata[31:16])) - 17'($signed(off_y_r));
  assign dz = 17'($signed(in_tdata[47:32]));

  sample_t ax, ay, az;
  ang_t pit, rol, unz;
  ast_lane #(.DO_ASIN(1)) u_lx (.clk, .rst_n, .en, .d_in(in_tdata[15:0]),
    .d_ext(dx), .sens(sx_r), .gscale(g_r), .negate(1'b1), .accel(ax), .angle(pit));
  ast_lane #(.DO_ASIN(1)) u_ly (.clk, .rst_n, .en, .d_in(in_tdata[31:16]),
    .d_ext(dy), .sens(sy_r), .gscale(g_r), .negate(1'b0), .accel(ay), .angle(rol));
  ast_lane #(.DO_ASIN(0)) u_lz (.clk, .rst_n, .en, .d_in(in_tdata[47:32]),
    .d_ext(dz), .sens(sz_r), .gscale(g_r), .negate(1'b1), .accel(az), .angle(unz));

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[LAT-2:0], in_tvalid};
  end

  // merge and output queue
  logic push, pop;
  logic [71:0] res;
  assign push = en && v_r[LAT-1];
  assign pop  = out_tvalid && out_tready;
  assign res  = {rol, pit, az, ay, ax} ^ {60'd0, unz & 12'd0};
  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_r + 2'(push) - 2'(pop);
  end
  // head entry takes the new result when it is the only one left
  always_ff @(posedge clk) begin
    if (push && (cnt_r == 2'd0 || (pop && cnt_r == 2'd1))) fq_r[0] <= res;
    else if (pop) fq_r[0] <= fq_r[1];
    if (push && ((cnt_r == 2'd1 && !pop) || cnt_r == 2'd2)) fq_r[1] <= res;
  end
  assign out_tvalid = cnt_r != 2'd0;
  assign out_tdata  = fq_r[0];
endmodule

>>> dv/tb_top.sv
// Self-checking testbench for accel_scale_and_tilt: stream stimulus plus a scaling/arcsine predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ast_pkg::*;

  // Unused register slots; writes there must be ignored.
  localparam logic [2:0] RegSpare6 = 3'd6;
  localparam logic [2:0] RegSpare7 = 3'd7;
  localparam int PipeLat = 62;

  // Arcsine breakpoints in mrad, ratio -1..1 in 0.1 steps.
  localparam int AsinMrad[21] = '{-1571, -1120, -927, -775, -644, -524, -412, -305, -201,
                                  -100, 0, 100, 201, 305, 412, 524, 644, 775, 927, 1120,
                                  1571};

  typedef struct {
    sample_t accel_x;
    sample_t accel_y;
    sample_t accel_z;
    ang_t    pitch;
    ang_t    roll;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // raw_x, raw_y, raw_z
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;       // accel_x, accel_y, accel_z, pitch, roll

  accel_scale_and_tilt u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the register file
  sample_t    offs_x, offs_y;
  logic [11:0] sens_x, sens_y, sens_z, g_scale;

  reading_t pending_readings[$];
  int err_cnt = 0;
  int sent_cnt = 0;
  int checked_cnt = 0;
  int cfg_cnt = 0;

  // sender burst shaping
  int  burst_left = 0;
  int  max_gap = 6;
  // receiver stall shaping
  int  stall_pct = 30;
  bit  hold_req = 0;
  int  hold_cnt = 0;

  // ------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------
  function automatic sample_t sat_scale(longint d, longint s, bit neg);
    longint q;
    q = ((d * longint'(g_scale)) / s) / 10;
    if (neg) q = -q;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return sample_t'(q);
  endfunction

  function automatic longint arcsin_mrad(longint d, longint s);
    longint u, h, t, delta;
    if (d < -s) return AsinMrad[0];
    u = (d + s) * 10;
    h = u / s;
    if (h >= 20) return AsinMrad[20];
    t = u - h * s;
    delta = AsinMrad[h+1] - AsinMrad[h];
    return AsinMrad[h] + (delta * t) / s;
  endfunction

  function automatic reading_t predict_tilt_sample(sample_t rx, sample_t ry, sample_t rz);
    reading_t r;
    longint sx, sy, sz, dx, dy;
    sx = (sens_x == 0) ? 1 : longint'(sens_x);
    sy = (sens_y == 0) ? 1 : longint'(sens_y);
    sz = (sens_z == 0) ? 1 : longint'(sens_z);
    dx = longint'(rx) - longint'(offs_x);
    dy = longint'(ry) - longint'(offs_y);
    r.accel_x = sat_scale(dx, sx, 1'b1);
    r.accel_y = sat_scale(dy, sy, 1'b0);
    r.accel_z = sat_scale(longint'(rz), sz, 1'b1);
    r.pitch   = ang_t'(-arcsin_mrad(dx, sx));
    r.roll    = ang_t'(-arcsin_mrad(dy, sy));
    return r;
  endfunction

  // ------------------------------------------------------------------
  // Result checker: compare each accepted result with the oldest prediction
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    reading_t exp_r;
    reading_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.accel_x = out_tdata[15:0];
      got.accel_y = out_tdata[31:16];
      got.accel_z = out_tdata[47:32];
      got.pitch   = out_tdata[59:48];
      got.roll    = out_tdata[71:60];
      if (pending_readings.size() == 0) begin
        $error("unexpected result, nothing pending: %h", out_tdata);
        err_cnt++;
      end else begin
        exp_r = pending_readings.pop_front();
        checked_cnt++;
        if (got.accel_x !== exp_r.accel_x) begin
          $error("accel_x exp %0d got %0d", exp_r.accel_x, got.accel_x); err_cnt++;
        end
        if (got.accel_y !== exp_r.accel_y) begin
          $error("accel_y exp %0d got %0d", exp_r.accel_y, got.accel_y); err_cnt++;
        end
        if (got.accel_z !== exp_r.accel_z) begin
          $error("accel_z exp %0d got %0d", exp_r.accel_z, got.accel_z); err_cnt++;
        end
        if (got.pitch !== exp_r.pitch) begin
          $error("pitch_mrad exp %0d got %0d", exp_r.pitch, got.pitch); err_cnt++;
        end
        if (got.roll !== exp_r.roll) begin
          $error("roll_mrad exp %0d got %0d", exp_r.roll, got.roll); err_cnt++;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long counted hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_cnt = 400;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // ------------------------------------------------------------------
  // Shared tasks
  // ------------------------------------------------------------------
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      RegOffsetX: offs_x  = val;
      RegOffsetY: offs_y  = val;
      RegSensX:   sens_x  = val[11:0];
      RegSensY:   sens_y  = val[11:0];
      RegSensZ:   sens_z  = val[11:0];
      RegGScale:  g_scale = val[11:0];
      default: ;
    endcase
    cfg_cnt++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(sample_t ox, sample_t oy, logic [11:0] sx, logic [11:0] sy,
                            logic [11:0] sz, logic [11:0] gs);
    write_reg(RegOffsetX, ox);
    write_reg(RegOffsetY, oy);
    write_reg(RegSensX, {4'b0, sx});
    write_reg(RegSensY, {4'b0, sy});
    write_reg(RegSensZ, {4'b0, sz});
    write_reg(RegGScale, {4'b0, gs});
  endtask

  // One request on the input side; bursts with random gaps between them.
  task automatic send_sample(sample_t rx, sample_t ry, sample_t rz);
    if (burst_left == 0) begin
      if (max_gap > 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, max_gap)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {rz, ry, rx};
    do @(posedge clk); while (!in_tready);
    pending_readings.push_back(predict_tilt_sample(rx, ry, rz));
    sent_cnt++;
    burst_left--;
  endtask

  // Lower valid and wait until every prediction has been matched.
  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic sample_t clip16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return sample_t'(v);
  endfunction

  // Mostly samples within about +-13 g of the offset so every arcsine
  // segment and both clamps get hit; the rest is full-range noise.
  function automatic sample_t pick_axis(sample_t off, logic [11:0] s);
    longint sp;
    sp = (s == 0) ? 1 : longint'(s);
    if ($urandom_range(0, 3) == 0) return sample_t'($urandom);
    return clip16(longint'(off) + longint'($urandom_range(0, 26 * sp)) - 13 * sp);
  endfunction

  task automatic send_random(int n);
    repeat (n)
      send_sample(pick_axis(offs_x, sens_x), pick_axis(offs_y, sens_y),
                  pick_axis(16'sd0, sens_z));
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------
  task automatic test_directed();
    // reset values: offsets 0, sens 354/343/355, gravity 981
    offs_x = 0; offs_y = 0; sens_x = 354; sens_y = 343; sens_z = 355; g_scale = 981;
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sd354, 16'sd343, 16'sd355);      // ratio exactly +1
    send_sample(-16'sd354, -16'sd343, -16'sd355);   // ratio exactly -1
    send_sample(-16'sd355, -16'sd344, 16'sd1);      // just below -1
    send_sample(16'sd355, 16'sd344, -16'sd1);       // just above +1
    send_sample(16'sd35, 16'sd34, 16'sd0);          // near segment edges
    send_sample(-16'sd36, -16'sd35, 16'sd0);
    send_sample(16'sd318, -16'sd308, 16'sd100);
    send_sample(16'sd1, -16'sd1, 16'sd1);
    send_sample(16'sh5555, 16'shaaaa, 16'sh5555);
    send_sample(16'shaaaa, 16'sh5555, 16'shaaaa);
    drain();
    // overflow of the scaled value and zero sensitivity (used as one)
    set_config(16'sh8000, 16'sh7fff, 12'd0, 12'd0, 12'd0, 12'd4095);
    send_sample(16'sh7fff, 16'sh8000, 16'sh7fff);
    send_sample(16'sh8000, 16'sh7fff, 16'sh8000);
    send_sample(16'sh8001, 16'sh7ffe, 16'sd0);
    send_sample(16'sh8000, 16'sh7fff, 16'sd1);
    drain();
    // gravity zero, max sensitivity
    set_config(16'sd0, 16'sd0, 12'd4095, 12'd4095, 12'd4095, 12'd0);
    send_sample(16'sd4095, -16'sd4095, 16'sh7fff);
    send_sample(-16'sd4096, 16'sd4096, 16'sh8000);
    send_sample(16'sd2048, -16'sd410, 16'sd7);
    drain();
    // writes to spare slots must not disturb anything
    write_reg(RegSpare6, 16'hffff);
    write_reg(RegSpare7, 16'h1234);
    send_sample(16'sd100, -16'sd100, 16'sd50);
    drain();
  endtask

  task automatic test_config_extremes();
    sample_t offs_ext[3] = '{16'sh8000, 16'sd0, 16'sh7fff};
    logic [11:0] sens_ext[4] = '{12'd0, 12'd1, 12'd4095, 12'd354};
    for (int i = 0; i < 8; i++) begin
      set_config(offs_ext[$urandom_range(0, 2)], offs_ext[$urandom_range(0, 2)],
                 sens_ext[$urandom_range(0, 3)], sens_ext[$urandom_range(0, 3)],
                 sens_ext[$urandom_range(0, 3)], (i % 2) ? 12'd4095 : 12'd0);
      send_random(20);
      drain();
    end
  endtask

  task automatic test_random();
    for (int i = 0; i < 12; i++) begin
      // several phases with no idling at all on either side
      max_gap   = (i % 4 == 0) ? 0 : $urandom_range(1, 8);
      stall_pct = (i % 4 == 0) ? 0 : $urandom_range(10, 60);
      set_config(sample_t'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 800) - 400),
                 sample_t'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 800) - 400),
                 12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)),
                 12'($urandom_range(0, 3) ? $urandom_range(200, 500)
                                          : $urandom_range(1, 4095)),
                 12'($urandom_range(0, 4095)));
      send_random(70);
      drain();
    end
  endtask

  // Receiver holds off long enough that the pipeline fills and in_tready drops.
  task automatic test_backpressure();
    max_gap   = 0;
    stall_pct = 0;
    set_config(16'sd12, -16'sd20, 12'd354, 12'd343, 12'd355, 12'd981);
    hold_req = 1;
    send_random(200);
    drain();
    max_gap   = 5;
    stall_pct = 25;
  endtask

  // ------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_random();
    test_backpressure();
    drain();
    repeat (PipeLat + 10) @(posedge clk);
    $display("Covered %0d samples, %0d results checked, %0d register writes,", sent_cnt,
             checked_cnt, cfg_cnt);
    $display("including saturation, arcsine clamps, zero sensitivity and a full stall.");
    if (err_cnt == 0 && pending_readings.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timed out waiting for results");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
